[design/bf5_pkg.sv]
`default_nettype none

package bf5_pkg;

  localparam int PIX_W      = 8;
  localparam int COLSUM_W   = 11;
  localparam int WSUM_W     = 13;
  localparam int LS_W       = 32;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PROD_W     = 26;

  localparam int DEFAULT_MAX_WIDTH = 2048;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  localparam int WIN_EDGE = 4;

  // floor(x / 25) == (x * 5243) >> 17 for every x below 43690.
  localparam logic [PROD_W-1:0] DIV25_MUL = PROD_W'(5243);
  localparam int                DIV25_SHIFT = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

[design/box_filter_5x5_mean.sv]
// A pixel word is registered in stage one, then stage two, then the output register.
// Throughput: one pixel word per cycle unless stalled, set by one line store read and one
// line store write per cycle and a window sum formed from five column sums once per pixel.
// Stalls: a result word held by out_ready low stops the whole pipeline and drops in_ready.
// Reset (rst_n low, synchronous) clears counters, column sums, pipeline valids
// and sets frame width to 640 and height to 480; line store contents are kept.
`default_nettype none

module box_filter_5x5_mean
  import bf5_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      in_pixel_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PIX_W-1:0]      out_mean_value,
  output logic                       out_frame_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;

  logic en, acc;
  logic line_end, frame_end, produce;
  logic [CMPW-1:0] col_plus1;
  logic [FH_W-1:0] row_plus1;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_addr_r;
  logic             s1_prod_r;
  logic             s1_last_r;

  logic             s2_valid_r;
  logic             s2_last_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_mean_value_r;
  logic             out_frame_last_r;

  logic [LS_W-1:0]     stored;
  logic [LS_W-1:0]     wr_word;
  logic [COLSUM_W-1:0] colsum;
  logic [COLSUM_W-1:0] cs_r [5];
  logic [WSUM_W-1:0]   sum_r, sum_nxt;
  logic [PROD_W-1:0]   prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign acc      = in_valid && en;

  assign col_plus1 = CMPW'(col_cnt_r) + CMPW'(1);
  assign row_plus1 = FH_W'(row_cnt_r) + FH_W'(1);
  assign line_end  = (col_plus1 >= CMPW'(frame_width_r))
                  || (col_cnt_r == CW'(MAX_WIDTH - 1));
  assign frame_end = line_end
                  && ((row_plus1 >= frame_height_r) || (row_cnt_r == '1));
  assign produce   = (row_cnt_r >= ROW_W'(WIN_EDGE)) && (col_cnt_r >= CW'(WIN_EDGE));

  always_comb begin
    col_cnt_nxt = col_cnt_r + CW'(1);
    row_cnt_nxt = row_cnt_r;
    if (line_end) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = frame_end ? '0 : row_cnt_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  bf5_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col_cnt_r),
    .rd_data (stored),
    .wr_en   (en && s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data (wr_word)
  );

  assign wr_word = {stored[LS_W-PIX_W-1:0], s1_pix_r};
  assign colsum  = COLSUM_W'(s1_pix_r)
                 + COLSUM_W'(stored[7:0])   + COLSUM_W'(stored[15:8])
                 + COLSUM_W'(stored[23:16]) + COLSUM_W'(stored[31:24]);
  assign sum_nxt = WSUM_W'(colsum) + WSUM_W'(cs_r[0]) + WSUM_W'(cs_r[1])
                 + WSUM_W'(cs_r[2]) + WSUM_W'(cs_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= in_pixel_value;
      s1_addr_r <= col_cnt_r;
      s1_prod_r <= produce;
      s1_last_r <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) begin
        cs_r[k] <= '0;
      end
      sum_r <= '0;
    end else if (en && s1_valid_r) begin
      for (int k = 4; k > 0; k--) begin
        cs_r[k] <= cs_r[k-1];
      end
      cs_r[0] <= colsum;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r  <= s1_valid_r && s1_prod_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign prod = PROD_W'(sum_r) * DIV25_MUL;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last_r        <= s1_last_r;
      out_mean_value_r <= prod[DIV25_SHIFT +: PIX_W];
      out_frame_last_r <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_value_r;
  assign out_frame_last = out_frame_last_r;

`ifndef ASSERT_OFF
  a_sum_tracks_columns: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (sum_r == WSUM_W'(cs_r[0]) + WSUM_W'(cs_r[1]) + WSUM_W'(cs_r[2])
                           + WSUM_W'(cs_r[3]) + WSUM_W'(cs_r[4])))
    else $error("Window sum differs from the sum of the column sums.");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_cnt_r) < MAX_WIDTH)
    else $error("Column counter beyond the line store depth.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !en) |=> (s1_valid_r && $stable(s1_addr_r) && $stable(s1_pix_r)))
    else $error("First stage moved during a stall.");
`endif

endmodule

`default_nettype wire

[design/bf5_line_store.sv]
`default_nettype none

module bf5_line_store
  import bf5_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_WIDTH,
  parameter int AW    = $clog2(DEFAULT_MAX_WIDTH)
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output logic      [LS_W-1:0] rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire logic [LS_W-1:0] wr_data
);

  logic [LS_W-1:0] mem [DEPTH];
  logic [LS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the word being written in the same cycle returns the new word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
